// ----- src/cbe_pkg.sv -----
// Package for the cubic Bezier easing block: widths, constants, types and fixed-point helpers.
`default_nettype none

package cbe_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS        = 16;
  localparam int BISECT_STEPS_DEF = 8;
  localparam int PROG_W           = 17;
  localparam int CTRL_X_W         = 17;
  localparam int CTRL_Y_W         = 19;
  localparam int EASED_W          = 19;
  localparam int VAL_W            = 24;
  localparam int TDATA_IN_W       = 24;
  localparam int TDATA_OUT_W      = 24;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 19;

  // Saturation bounds of the eased value
  localparam int EASED_MIN = -131072;
  localparam int EASED_MAX = 196608;

  // Register reset values
  localparam logic [CTRL_X_W-1:0]        CTRL_X1_RST = CTRL_X_W'(0);
  localparam logic signed [CTRL_Y_W-1:0] CTRL_Y1_RST = CTRL_Y_W'(0);
  localparam logic [CTRL_X_W-1:0]        CTRL_X2_RST = CTRL_X_W'(1 << FRAC_BITS);
  localparam logic signed [CTRL_Y_W-1:0] CTRL_Y2_RST = CTRL_Y_W'(1 << FRAC_BITS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL_X1 = 2'd0,
    REG_CTRL_Y1 = 2'd1,
    REG_CTRL_X2 = 2'd2,
    REG_CTRL_Y2 = 2'd3
  } cfg_reg_e;

  // Internal curve value, wide enough for any control point pattern
  typedef logic signed [VAL_W-1:0] val_t;

  // Bisection interval and target carried along the pipe
  typedef struct packed {
    logic [PROG_W-1:0] t;
    logic [PROG_W-1:0] lo;
    logic [PROG_W-1:0] hi;
    logic [PROG_W-1:0] mid;
  } bis_t;

  // First de Casteljau level
  typedef struct packed {
    bis_t              bis;
    logic [PROG_W-1:0] mid_lo;
    logic [PROG_W-1:0] mid_hi;
    val_t              q0;
    val_t              q1;
    val_t              q2;
  } st1_t;

  // Second de Casteljau level
  typedef struct packed {
    bis_t              bis;
    logic [PROG_W-1:0] mid_lo;
    logic [PROG_W-1:0] mid_hi;
    val_t              r0;
    val_t              r1;
  } st2_t;

  localparam val_t             FX_ONE_V    = val_t'(1 << FRAC_BITS);
  localparam val_t             EASED_MIN_V = val_t'(EASED_MIN);
  localparam val_t             EASED_MAX_V = val_t'(EASED_MAX);
  localparam logic [PROG_W-1:0] HI_INIT    = PROG_W'(1 << FRAC_BITS);
  localparam logic [PROG_W-1:0] MID_INIT   = PROG_W'(1 << (FRAC_BITS - 1));

  // floor(s * v / 2^FRAC_BITS) with s a non-negative curve parameter
  function automatic val_t fx_mul(input logic [PROG_W-1:0] s, input val_t v);
    logic signed [PROG_W+VAL_W:0] p;
    p = $signed({1'b0, s}) * v;
    return p[FRAC_BITS+VAL_W-1:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

// ----- src/cubic_bezier_easing.sv -----
// Top level of the cubic Bezier easing block: bisection and evaluation pipeline.
//
// Usage:
//   Slave stream takes one progress word t (unsigned Q1.16, 65536 is one) per handshake.
//   Master stream returns one eased word y (signed Q3.16) per progress word, in order.
//   The config port writes the inner control points (x1, y1, x2, y2) by index;
//   write only while no word is in flight.
// Timing:
//   Each bisection step and the final y evaluation take three register stages
//   (one de Casteljau level each), followed by the output buffer head register.
//   Throughput is one word per cycle while the output buffer is not full, set by
//   the fully pipelined multiplier levels.
// Reset:
//   Clears all stage valids and the output buffer, and loads the control
//   points of the linear curve (0, 0) and (1, 1).
// Stall:
//   A two-word output buffer parts the pipe from the receiver. The pipe keeps
//   accepting while one word waits; it freezes only once the buffer is full,
//   and then s_axis_tready is low. No word is lost or repeated.
`default_nettype none

module cubic_bezier_easing
  import cbe_pkg::*;
#(
  parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // progress[16:0], zero fill above
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // eased[18:0], zero fill above
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Control point registers
  logic [CTRL_X_W-1:0]        ctrl_x1_q, ctrl_x2_q;
  logic signed [CTRL_Y_W-1:0] ctrl_y1_q, ctrl_y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_x1_q <= CTRL_X1_RST;
      ctrl_y1_q <= CTRL_Y1_RST;
      ctrl_x2_q <= CTRL_X2_RST;
      ctrl_y2_q <= CTRL_Y2_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CTRL_X1: ctrl_x1_q <= cfg_wdata_i[CTRL_X_W-1:0];
        REG_CTRL_Y1: ctrl_y1_q <= cfg_wdata_i[CTRL_Y_W-1:0];
        REG_CTRL_X2: ctrl_x2_q <= cfg_wdata_i[CTRL_X_W-1:0];
        REG_CTRL_Y2: ctrl_y2_q <= cfg_wdata_i[CTRL_Y_W-1:0];
        default: ;
      endcase
    end
  end

  // Extend control points to the internal width
  val_t px1, px2, py1, py2;
  assign px1 = val_t'({{(VAL_W-CTRL_X_W){1'b0}}, ctrl_x1_q});
  assign px2 = val_t'({{(VAL_W-CTRL_X_W){1'b0}}, ctrl_x2_q});
  assign py1 = val_t'(ctrl_y1_q);
  assign py2 = val_t'(ctrl_y2_q);

  // Whole pipe advances unless the output buffer is full
  logic pipe_en;
  logic skid_v_q;
  assign pipe_en       = ~skid_v_q;
  assign s_axis_tready = pipe_en;

  // Interval entering each evaluation
  bis_t ev_bis [0:BISECT_STEPS];
  logic ev_v   [0:BISECT_STEPS];

  assign ev_bis[0] = '{t: s_axis_tdata[PROG_W-1:0], lo: '0, hi: HI_INIT, mid: MID_INIT};
  assign ev_v[0]   = s_axis_tvalid;

  logic [EASED_W-1:0] res_q;
  logic               res_v_q;

  for (genvar k = 0; k <= BISECT_STEPS; k++) begin : g_eval
    val_t p1, p2;
    st1_t s1_d, s1_q;
    st2_t s2_d, s2_q;
    logic s1_v_q, s2_v_q;
    val_t b;

    assign p1 = (k == BISECT_STEPS) ? py1 : px1;
    assign p2 = (k == BISECT_STEPS) ? py2 : px2;

    // First level, plus both candidate midpoints of the next interval
    always_comb begin
      s1_d.bis    = ev_bis[k];
      s1_d.mid_lo = ev_bis[k].lo + ((ev_bis[k].mid - ev_bis[k].lo) >> 1);
      s1_d.mid_hi = ev_bis[k].mid + ((ev_bis[k].hi - ev_bis[k].mid) >> 1);
      s1_d.q0     = fx_mul(ev_bis[k].mid, p1);
      s1_d.q1     = p1 + fx_mul(ev_bis[k].mid, p2 - p1);
      s1_d.q2     = p2 + fx_mul(ev_bis[k].mid, FX_ONE_V - p2);
    end

    // Second level
    always_comb begin
      s2_d.bis    = s1_q.bis;
      s2_d.mid_lo = s1_q.mid_lo;
      s2_d.mid_hi = s1_q.mid_hi;
      s2_d.r0     = s1_q.q0 + fx_mul(s1_q.bis.mid, s1_q.q1 - s1_q.q0);
      s2_d.r1     = s1_q.q1 + fx_mul(s1_q.bis.mid, s1_q.q2 - s1_q.q1);
    end

    // Final level
    assign b = s2_q.r0 + fx_mul(s2_q.bis.mid, s2_q.r1 - s2_q.r0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_v_q <= 1'b0;
        s2_v_q <= 1'b0;
      end else if (pipe_en) begin
        s1_v_q <= ev_v[k];
        s2_v_q <= s1_v_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        s1_q <= s1_d;
        s2_q <= s2_d;
      end
    end

    if (k < BISECT_STEPS) begin : g_bis
      bis_t nxt_d, nxt_q;
      logic nxt_v_q;

      // Keep the upper half when x(mid) is below t, else the lower half
      always_comb begin
        nxt_d = s2_q.bis;
        if (b < val_t'({{(VAL_W-PROG_W){1'b0}}, s2_q.bis.t})) begin
          nxt_d.lo  = s2_q.bis.mid;
          nxt_d.mid = s2_q.mid_hi;
        end else begin
          nxt_d.hi  = s2_q.bis.mid;
          nxt_d.mid = s2_q.mid_lo;
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          nxt_v_q <= 1'b0;
        end else if (pipe_en) begin
          nxt_v_q <= s2_v_q;
        end
      end

      always_ff @(posedge clk_i) begin
        if (pipe_en) begin
          nxt_q <= nxt_d;
        end
      end

      assign ev_bis[k+1] = nxt_q;
      assign ev_v[k+1]   = nxt_v_q;
    end else begin : g_out
      val_t y_sat;

      // Saturate y to the output range
      always_comb begin
        if (b < EASED_MIN_V) begin
          y_sat = EASED_MIN_V;
        end else if (b > EASED_MAX_V) begin
          y_sat = EASED_MAX_V;
        end else begin
          y_sat = b;
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          res_v_q <= 1'b0;
        end else if (pipe_en) begin
          res_v_q <= s2_v_q;
        end
      end

      always_ff @(posedge clk_i) begin
        if (pipe_en) begin
          res_q <= y_sat[EASED_W-1:0];
        end
      end
    end
  end

  // Two-word output buffer: head drives the port, skid catches one word on a stall
  logic [EASED_W-1:0] head_q, head_d, skid_q, skid_d;
  logic               head_v_q, head_v_d, skid_v_d;
  logic               push, pop;

  assign push = pipe_en & res_v_q;
  assign pop  = head_v_q & m_axis_tready;

  always_comb begin
    head_d   = head_q;
    head_v_d = head_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        head_d   = res_q;
        head_v_d = push;
      end
    end else if (push) begin
      if (head_v_q) begin
        skid_d   = res_q;
        skid_v_d = 1'b1;
      end else begin
        head_d   = res_q;
        head_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = head_v_q;
  assign m_axis_tdata  = {{(TDATA_OUT_W-EASED_W){1'b0}}, head_q};

  // Skid entry is only ever used behind a full head
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> head_v_q)
    else $error("output skid holds a word while head is empty");

  // Skid fills only when the head was stalled
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(head_v_q && !m_axis_tready))
    else $error("output skid filled without a stalled head");

  // Final interval has shrunk by exactly one half per step, midpoint centered
  a_final_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_v[BISECT_STEPS] |->
      (ev_bis[BISECT_STEPS].hi - ev_bis[BISECT_STEPS].lo ==
         PROG_W'(HI_INIT >> BISECT_STEPS)) &&
      (ev_bis[BISECT_STEPS].mid == ev_bis[BISECT_STEPS].lo +
         ((ev_bis[BISECT_STEPS].hi - ev_bis[BISECT_STEPS].lo) >> 1)))
    else $error("bisection interval lost its width or midpoint");

  // Delivered value stays inside the saturation range
  a_eased_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(head_q) >= EASED_MIN) && ($signed(head_q) <= EASED_MAX))
    else $error("eased word outside saturation range");

endmodule

`default_nettype wire

// ----- test/cbe_easing_checker.sv -----
// Checker for the cubic Bezier easing block: watches the streams, predicts every eased word.
module cbe_easing_checker
  import cbe_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [TDATA_IN_W-1:0]  s_tdata_i,   // progress[16:0], zero fill above
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [TDATA_OUT_W-1:0] m_tdata_i,   // eased[18:0], zero fill above
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNIT      = longint'(1) << FRAC_BITS;
  localparam longint HALF_UNIT = longint'(1) << (FRAC_BITS - 1);
  localparam int     REPORT_MAX = 10;

  typedef struct {
    logic [PROG_W-1:0]      progress;
    logic [TDATA_OUT_W-1:0] word;
  } eased_exp_t;

  // Shadow copy of the control points
  longint x1_q, y1_q, x2_q, y2_q;
  eased_exp_t eased_q[$];
  int mismatches = 0;

  // Full 64-bit product, arithmetic shift drops the fraction toward minus infinity
  function automatic longint fx_prod(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // One coordinate of the curve at parameter s, three de Casteljau levels
  function automatic longint curve_at(input longint s, input longint p1, input longint p2);
    longint q0, q1, q2, r0, r1;
    q0 = fx_prod(s, p1);
    q1 = p1 + fx_prod(s, p2 - p1);
    q2 = p2 + fx_prod(s, UNIT - p2);
    r0 = q0 + fx_prod(s, q1 - q0);
    r1 = q1 + fx_prod(s, q2 - q1);
    return r0 + fx_prod(s, r1 - r0);
  endfunction

  // Bisect for the parameter where x meets t, then evaluate y there and saturate
  function automatic logic signed [EASED_W-1:0] predict_eased(input logic [PROG_W-1:0] t);
    longint lo, hi, mid, y;
    lo = 0;
    hi = UNIT;
    for (int i = 0; i < BISECT_STEPS_DEF; i++) begin
      mid = lo + fx_prod(hi - lo, HALF_UNIT);
      if (curve_at(mid, x1_q, x2_q) < longint'(t)) lo = mid;
      else hi = mid;
    end
    mid = lo + fx_prod(hi - lo, HALF_UNIT);
    y = curve_at(mid, y1_q, y2_q);
    if (y < EASED_MIN) y = EASED_MIN;
    if (y > EASED_MAX) y = EASED_MAX;
    return EASED_W'(y);
  endfunction

  always @(posedge clk_i) begin : watch
    eased_exp_t want;
    if (!rst_ni) begin
      x1_q = longint'(CTRL_X1_RST);
      y1_q = longint'(CTRL_Y1_RST);
      x2_q = longint'(CTRL_X2_RST);
      y2_q = longint'(CTRL_Y2_RST);
      eased_q.delete();
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CTRL_X1: x1_q = longint'(cfg_wdata_i[CTRL_X_W-1:0]);
          REG_CTRL_Y1: y1_q = longint'($signed(cfg_wdata_i[CTRL_Y_W-1:0]));
          REG_CTRL_X2: x2_q = longint'(cfg_wdata_i[CTRL_X_W-1:0]);
          REG_CTRL_Y2: y2_q = longint'($signed(cfg_wdata_i[CTRL_Y_W-1:0]));
          default: ;
        endcase
      end
      // Compare each returned word with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (eased_q.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("[%0t] eased word %h arrived with nothing outstanding", $realtime,
                     m_tdata_i);
          mismatches++;
        end else begin
          want = eased_q.pop_front();
          if (m_tdata_i !== want.word) begin
            if (mismatches < REPORT_MAX)
              $display("[%0t] t=%0d: eased expected %0d (word %h), got %0d (word %h)",
                       $realtime, want.progress, $signed(want.word[EASED_W-1:0]), want.word,
                       $signed(m_tdata_i[EASED_W-1:0]), m_tdata_i);
            mismatches++;
          end
        end
      end
      // Predict every accepted progress word
      if (s_tvalid_i && s_tready_i) begin
        want.progress = s_tdata_i[PROG_W-1:0];
        want.word = {{(TDATA_OUT_W-EASED_W){1'b0}}, predict_eased(want.progress)};
        eased_q.push_back(want);
      end
    end
    pending_o    <= eased_q.size();
    fail_count_o <= mismatches;
  end

endmodule

// ----- test/cubic_bezier_easing_tb.sv -----
// Testbench top for the cubic Bezier easing block: clock, reset, stimulus and verdict.
module cubic_bezier_easing_tb
  import cbe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 35;
  localparam int SETTLE_CYCLES = 40;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;     // progress[16:0], zero fill above
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;          // eased[18:0], zero fill above
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_span = 0;

  // Progress corners: ends of the range, halves, bit patterns, above one
  int unsigned corner_t [0:19] = '{0, 1, 2, 255, 256, 16384, 21845, 32767, 32768, 32769,
                                   43690, 49152, 65534, 65535, 65536, 65537, 87381, 98304,
                                   131071, 131070};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cubic_bezier_easing DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  cbe_easing_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tdata_i    (s_tdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .m_tdata_i    (m_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: switch between always ready, random, sparse and long stalls
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_span <= $urandom_range(20, 200);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((rx_span % 24) < 4);
    endcase
  end

  // Abort when nothing moves on either stream for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one progress word, hold until taken, then maybe open a gap
  task automatic push_progress(input logic [PROG_W-1:0] t);
    int gap;
    s_tdata  <= TDATA_IN_W'(t);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write all four control points on consecutive cycles
  task automatic load_curve(input int x1, input int y1, input int x2, input int y2);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_CTRL_X1;
    cfg_wdata <= CFG_DATA_W'(x1);
    @(posedge clk);
    cfg_idx   <= REG_CTRL_Y1;
    cfg_wdata <= CFG_DATA_W'(y1);
    @(posedge clk);
    cfg_idx   <= REG_CTRL_X2;
    cfg_wdata <= CFG_DATA_W'(x2);
    @(posedge clk);
    cfg_idx   <= REG_CTRL_Y2;
    cfg_wdata <= CFG_DATA_W'(y2);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly uniform over zero to one, with ends, small values and values above one
  function automatic logic [PROG_W-1:0] rand_progress();
    int unsigned pick;
    pick = $urandom_range(0, 31);
    case (pick)
      0:       return ($urandom_range(0, 1) == 0) ? PROG_W'(0) : PROG_W'(65536);
      1:       return PROG_W'($urandom_range(65537, 131071));
      2, 3:    return PROG_W'($urandom_range(0, 255));
      4:       return PROG_W'($urandom_range(65280, 65536));
      default: return PROG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic feed_random(input int count);
    for (int i = 0; i < count; i++) push_progress(rand_progress());
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners on the reset (linear) curve
    foreach (corner_t[i]) push_progress(PROG_W'(corner_t[i]));
    drain_results();

    // Standard timing curves
    load_curve(16384, 6554, 16384, 65536);
    feed_random(PHASE_ITEMS);
    load_curve(27525, 0, 65536, 65536);
    feed_random(PHASE_ITEMS);
    load_curve(0, 0, 38011, 65536);
    feed_random(PHASE_ITEMS);
    load_curve(27525, 0, 38011, 65536);
    feed_random(PHASE_ITEMS);

    // Extreme overshoot at both range ends
    load_curve(0, -131072, 65536, 196608);
    feed_random(PHASE_ITEMS);
    load_curve(65536, 196608, 0, -131072);
    feed_random(PHASE_ITEMS);

    // Control x beyond one, unclamped
    load_curve(131071, 0, 131071, 65536);
    feed_random(PHASE_ITEMS);

    // Control y past the stated range so the output saturates low, then high
    load_curve(0, -262144, 0, -262144);
    feed_random(PHASE_ITEMS);
    load_curve(65536, 262143, 65536, 262143);
    feed_random(PHASE_ITEMS);

    // Random curves within the stated ranges
    repeat (3) begin
      load_curve($urandom_range(0, 65536), int'($urandom_range(0, 327680)) - 131072,
                 $urandom_range(0, 65536), int'($urandom_range(0, 327680)) - 131072);
      feed_random(PHASE_ITEMS);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/cbe_pkg.sv
src/cubic_bezier_easing.sv
test/cbe_easing_checker.sv
test/cubic_bezier_easing_tb.sv
